// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/qsm3_pkg.sv =====
`timescale 1ns / 1ps
package qsm3_pkg;
	localparam int Depth   = 64;
	localparam int IdxW    = 6;
	localparam int CntW    = 7;
	localparam int SpW     = 7;
	localparam int DataW   = 32;

	typedef enum logic [4:0] {
		ST_LOAD, ST_INIT, ST_POP, ST_RD_MID, ST_RD_LO, ST_RD_HI, ST_PIVOT,
		ST_SCAN_I, ST_CHK_I, ST_SCAN_J, ST_CHK_J, ST_SWAP_W1, ST_SWAP_W2,
		ST_PUSH_R, ST_PUSH_L, ST_OUT_RD, ST_OUT_WAIT, ST_OUT_HOLD
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_WRITE_IN, OP_INIT, OP_POP, OP_RD_MID, OP_RD_LO, OP_RD_HI,
		OP_PIVOT, OP_RD_I, OP_STEP_I, OP_RD_J, OP_STEP_J, OP_SWAP1, OP_SWAP2,
		OP_PUSH_R, OP_PUSH_L
	} op_t;

	typedef struct packed {
		op_t                op;
		logic               out_rd;
		logic               clear;
	} cmd_t;

	typedef struct packed {
		logic               stack_empty;
		logic               i_adv;
		logic               j_adv;
		logic               i_gt_j;
		logic               out_done;
	} sts_t;
endpackage

// ===== rtl/quicksort_median_of_three_unit.sv =====
`timescale 1ns / 1ps
// Quicksort unit, median-of-three pivot, Hoare partitioning.
// Input channel s_axis: tdata[31:0] = value, tlast = last_item. One item
// is taken per cycle while loading; tlast closes the set. Items past 64 are
// dropped and every result of that set then carries overflow.
// Output channel m_axis: tdata[31:0] = sorted_value, tlast = last_result,
// tuser = overflow. A set of N items is sorted in place through one element
// memory: each range is popped, its pivot picked and its halves pushed, each
// scan steps over one element at a time after a start step, and each swap
// writes both elements in turn.
// Results then leave one at a time, each through a read state and a wait state.
// A new set is accepted from the cycle after the last result of the set has
// entered the output register.
// A stalled receiver holds the output register; the sorter waits.
// Reset empties the set and the range stack; memory contents are not
// cleared.
module quicksort_median_of_three_unit import qsm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // value
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // sorted_value
	output logic        m_axis_tlast,
	output logic        m_axis_tuser   // overflow
);
	cmd_t cmd;
	sts_t sts;
	logic in_fire, out_free, out_load, last_flag, drop_flag;
	logic [DataW-1:0] rd_data;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	qsm3_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_last(s_axis_tlast), .out_free, .sts, .cmd,
		.in_ready(s_axis_tready), .out_load
	);

	qsm3_datapath u_dp (
		.clk, .arst_n, .cmd, .in_value(s_axis_tdata), .sts, .rd_data,
		.last_flag, .drop_flag
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (out_load) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= rd_data;
			m_axis_tlast <= last_flag;
			m_axis_tuser <= drop_flag;
		end
	end
endmodule

// ===== rtl/qsm3_datapath.sv =====
`timescale 1ns / 1ps
module qsm3_datapath import qsm3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [DataW-1:0] in_value,
	output sts_t             sts,
	output logic [DataW-1:0] rd_data,
	output logic             last_flag,
	output logic             drop_flag
);
	logic [DataW-1:0] mem_q [Depth];
	logic [11:0]      stk_q [Depth];
	logic [CntW-1:0]  count_q;
	logic [SpW-1:0]   sp_q;
	logic             drop_q;
	logic [IdxW-1:0]  lo_q, hi_q, i_q, j_q;
	logic [DataW-1:0] a_q, b_q, piv_q, vi_q, vj_q, rdat_q;
	logic [IdxW:0]    isx_q, jsx_q;
	logic [CntW-1:0]  oidx_q;
	logic [IdxW-1:0]  raddr;
	logic [IdxW:0]    msum;
	logic [DataW-1:0] med;
	logic             i_lt, j_gt, ilim, jlim, at_last;
	logic [IdxW-1:0]  ii, jj;

	assign msum = {1'b0, lo_q} + {1'b0, hi_q};
	assign ii = isx_q[IdxW-1:0];
	assign jj = jsx_q[IdxW-1:0];

	// while scanning, fetch the neighbour so each step finds its element already read
	always_comb begin
		case (cmd.op)
			OP_RD_MID: raddr = msum[IdxW:1];
			OP_RD_LO:  raddr = lo_q;
			OP_RD_HI:  raddr = hi_q;
			OP_RD_I:   raddr = ii;
			OP_STEP_I: raddr = ii + IdxW'(1);
			OP_RD_J:   raddr = jj;
			OP_STEP_J: raddr = jj - IdxW'(1);
			default:   raddr = oidx_q[IdxW-1:0];
		endcase
	end

	// median of middle (a), left (b), right (read data)
	always_comb begin
		if ($signed(a_q) <= $signed(b_q))
			med = ($signed(a_q) >= $signed(rdat_q)) ? a_q :
				(($signed(rdat_q) <= $signed(b_q)) ? rdat_q : b_q);
		else
			med = ($signed(b_q) >= $signed(rdat_q)) ? b_q :
				(($signed(a_q) <= $signed(rdat_q)) ? a_q : rdat_q);
	end

	assign i_lt = $signed(rdat_q) < $signed(piv_q);
	assign j_gt = $signed(rdat_q) > $signed(piv_q);
	assign ilim = ii < hi_q;
	assign jlim = jj > lo_q;
	assign at_last = ((oidx_q + CntW'(1)) == count_q);

	always_ff @(posedge clk) begin
		rdat_q <= mem_q[raddr];
		case (cmd.op)
			OP_WRITE_IN: if (count_q < CntW'(Depth)) mem_q[count_q[IdxW-1:0]] <= in_value;
			OP_SWAP1:    mem_q[ii] <= vj_q;
			OP_SWAP2:    mem_q[jj] <= vi_q;
			OP_PUSH_R:   stk_q[sp_q[IdxW-1:0]] <= {ii, hi_q};
			OP_PUSH_L:   stk_q[sp_q[IdxW-1:0]] <= {lo_q, jj};
			OP_INIT:     stk_q[0] <= {IdxW'(0), IdxW'(count_q - CntW'(1))};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sp_q <= '0;
			drop_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				sp_q <= '0;
				drop_q <= 1'b0;
				oidx_q <= '0;
			end else begin
				if (cmd.out_rd) oidx_q <= oidx_q + CntW'(1);
				case (cmd.op)
					OP_WRITE_IN: begin
						if (count_q < CntW'(Depth)) count_q <= count_q + CntW'(1);
						else drop_q <= 1'b1;
					end
					OP_INIT: sp_q <= (count_q > CntW'(1)) ? SpW'(1) : '0;
					OP_POP: sp_q <= sp_q - SpW'(1);
					OP_PUSH_R: if ({1'b0, isx_q} < {2'b0, hi_q} && sp_q < SpW'(Depth))
						sp_q <= sp_q + SpW'(1);
					OP_PUSH_L: if (!jsx_q[IdxW] && jj > lo_q && sp_q < SpW'(Depth))
						sp_q <= sp_q + SpW'(1);
					default: ;
				endcase
			end
		end
	end

	// payload registers of the partition loop
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_POP: begin
				lo_q <= stk_q[sp_q[IdxW-1:0] - IdxW'(1)][11:6];
				hi_q <= stk_q[sp_q[IdxW-1:0] - IdxW'(1)][5:0];
			end
			OP_RD_LO:  a_q <= rdat_q;
			OP_RD_HI:  b_q <= rdat_q;
			OP_PIVOT: begin
				piv_q <= med;
				isx_q <= {1'b0, lo_q};
				jsx_q <= {1'b0, hi_q};
			end
			OP_STEP_I: begin
				vi_q <= rdat_q;
				if (i_lt && ilim) isx_q <= isx_q + (IdxW+1)'(1);
			end
			OP_STEP_J: begin
				vj_q <= rdat_q;
				if (j_gt && jlim) jsx_q <= jsx_q - (IdxW+1)'(1);
			end
			OP_SWAP2: begin
				isx_q <= isx_q + (IdxW+1)'(1);
				jsx_q <= jsx_q - (IdxW+1)'(1);
			end
			default: ;
		endcase
	end

	// j only drops below zero as minus one; i never does
	always_comb begin
		sts.stack_empty = (sp_q == '0);
		sts.i_adv = i_lt && ilim;
		sts.j_adv = j_gt && jlim;
		sts.i_gt_j = jsx_q[IdxW] || (isx_q > jsx_q);
		sts.out_done = at_last;
	end

	assign rd_data = rdat_q;
	assign last_flag = at_last;
	assign drop_flag = drop_q;
endmodule

// ===== rtl/qsm3_ctrl.sv =====
`timescale 1ns / 1ps
module qsm3_ctrl import qsm3_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic in_last,
	input  logic out_free,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_ready,
	output logic out_load
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:    if (in_fire && in_last) state_d = ST_INIT;
			ST_INIT:    state_d = ST_POP;
			ST_POP:     state_d = sts.stack_empty ? ST_OUT_RD : ST_RD_MID;
			ST_RD_MID:  state_d = ST_RD_LO;
			ST_RD_LO:   state_d = ST_RD_HI;
			ST_RD_HI:   state_d = ST_PIVOT;
			ST_PIVOT:   state_d = ST_SCAN_I;
			ST_SCAN_I:  state_d = ST_CHK_I;
			ST_CHK_I:   state_d = sts.i_adv ? ST_CHK_I : ST_SCAN_J;
			ST_SCAN_J:  state_d = ST_CHK_J;
			ST_CHK_J:   state_d = sts.j_adv ? ST_CHK_J : ST_SWAP_W1;
			ST_SWAP_W1: state_d = sts.i_gt_j ? ST_PUSH_R : ST_SWAP_W2;
			ST_SWAP_W2: state_d = ST_OUT_HOLD;
			ST_OUT_HOLD: state_d = sts.i_gt_j ? ST_PUSH_R : ST_SCAN_I;
			ST_PUSH_R:  state_d = ST_PUSH_L;
			ST_PUSH_L:  state_d = ST_POP;
			ST_OUT_RD:  state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: if (out_free) state_d = sts.out_done ? ST_LOAD : ST_OUT_RD;
			default:    state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		cmd.out_rd = 1'b0;
		cmd.clear = 1'b0;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_fire) cmd.op = OP_WRITE_IN;
			end
			ST_INIT:    cmd.op = OP_INIT;
			ST_POP:     if (!sts.stack_empty) cmd.op = OP_POP;
			ST_RD_MID:  cmd.op = OP_RD_MID;
			ST_RD_LO:   cmd.op = OP_RD_LO;
			ST_RD_HI:   cmd.op = OP_RD_HI;
			ST_PIVOT:   cmd.op = OP_PIVOT;
			ST_SCAN_I:  cmd.op = OP_RD_I;
			ST_CHK_I:   cmd.op = OP_STEP_I;
			ST_SCAN_J:  cmd.op = OP_RD_J;
			ST_CHK_J:   cmd.op = OP_STEP_J;
			ST_SWAP_W1: if (!sts.i_gt_j) cmd.op = OP_SWAP1;
			ST_SWAP_W2: cmd.op = OP_SWAP2;
			ST_PUSH_R:  cmd.op = OP_PUSH_R;
			ST_PUSH_L:  cmd.op = OP_PUSH_L;
			// advance the read index only once the item is in the output register
			ST_OUT_WAIT: if (out_free) begin
				out_load = 1'b1;
				cmd.out_rd = 1'b1;
				if (sts.out_done) cmd.clear = 1'b1;
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/qsm3_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qsm3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic        m_axis_tlast
);
	`CHK_NEXT(a_no_load_while_out, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
	`CHK_NEXT(a_tlast_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tlast), "tlast moved")
	`CHK_NEXT(a_close_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "set close not honoured")
endmodule

bind quicksort_median_of_three_unit qsm3_checker u_chk (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tlast,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tlast
);
